// ===== src/kps_pkg.sv =====
// Package for the 4x4 matrix keypad scanner.
// Holds the buffer sizing, codes, phase type and key map; no dependencies.
package kps_pkg;

	localparam int BUFFER_DEPTH = 16;
	localparam int BUF_IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

	localparam logic [7:0] DEBOUNCE_RESET = 8'd20;
	localparam logic [7:0] KEY_HASH = 8'h23;

	typedef enum logic [1:0] {
		ACT_SCAN  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	typedef enum logic [0:0] {
		REG_ENABLE   = 1'b0,
		REG_DEBOUNCE = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_SCAN     = 3'b001,
		PH_DEBOUNCE = 3'b010,
		PH_RELEASE  = 3'b100
	} phase_t;

	typedef struct packed {
		logic       found;
		logic [1:0] col;
	} col_hit_t;

	// row0 "123A", row1 "456B", row2 "789C", row3 "*0#D"
	function automatic logic [7:0] key_map(input logic [1:0] row, input logic [1:0] col);
		logic [7:0] code;
		case ({row, col})
			4'h0: code = 8'h31;
			4'h1: code = 8'h32;
			4'h2: code = 8'h33;
			4'h3: code = 8'h41;
			4'h4: code = 8'h34;
			4'h5: code = 8'h35;
			4'h6: code = 8'h36;
			4'h7: code = 8'h42;
			4'h8: code = 8'h37;
			4'h9: code = 8'h38;
			4'hA: code = 8'h39;
			4'hB: code = 8'h43;
			4'hC: code = 8'h2A;
			4'hD: code = 8'h30;
			4'hE: code = KEY_HASH;
			default: code = 8'h44;
		endcase
		return code;
	endfunction

	// lowest low column at or above 'from'
	function automatic col_hit_t find_low(input logic [3:0] cols, input logic [2:0] from);
		col_hit_t hit;
		hit = '0;
		for (int c = 3; c >= 0; c--) begin
			if (!cols[c] && (3'(c) >= from)) begin
				hit.found = 1'b1;
				hit.col = 2'(c);
			end
		end
		return hit;
	endfunction

endpackage

// ===== src/matrix_keypad_scanner_top.sv =====
// Top level of the 4x4 matrix keypad scanner: scan/debounce state, key buffer,
// result register. Depends on kps_pkg.
//
// Usage:
//  s_* stream: one item per scan tick or buffer command. s_tuser = action
//  (0 scan tick, 1 clear buffer, 2 read entry); s_tdata = col_levels, read_index.
//  m_* stream: one result per accepted item: row drive for the next sample,
//  reported key, buffer fill, read entry, with key_valid/read_valid in m_tuser.
//  cfg_we/cfg_index/cfg_data: register 0 enable, register 1 debounce_ticks.
//  Writing enable returns the scanner to row 0 and empties the buffer.
//  Result valid follows input accept in the next cycle, set by the single
//  result register after the state update; one item per cycle unless stalled.
//  When the receiver stalls, the result register holds and s_tready drops
//  until it is taken; a result taken in a cycle frees room for a new item in
//  that same cycle.
//  Reset: disabled, debounce 20 ticks, scan at row 0, buffer empty, no result.
//  While disabled, row_drive reads all-high and the buffer stays empty.
module matrix_keypad_scanner_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] col_levels, [7:4] read_index
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [3:0] row_drive, [11:4] key_code,
	                               // [16:12] buffer_count, [24:17] read_data
	output logic [1:0]  m_tuser,   // [0] key_valid, [1] read_valid
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import kps_pkg::*;

	logic             enable_q;
	logic [7:0]       debounce_q;
	logic [1:0]       row_q, row_n;
	phase_t           phase_q, phase_n;
	logic [1:0]       held_q, held_n;
	logic [7:0]       wait_q, wait_n;
	logic [CNT_W-1:0] count_q, count_n;
	logic [7:0]       store_q [BUFFER_DEPTH];

	logic             out_valid_q;
	logic [3:0]       row_drive_q;
	logic             key_valid_q;
	logic [7:0]       key_code_q;
	logic [CNT_W-1:0] count_out_q;
	logic [7:0]       read_data_q;
	logic             read_valid_q;

	logic             s_accept;
	action_t          action;
	logic [3:0]       cols;
	logic [3:0]       ridx;
	col_hit_t         hit_first, hit_next;
	logic             kvalid, rvalid, wr_en;
	logic [7:0]       kcode, rdata;
	logic [3:0]       drive;

	assign action = action_t'(s_tuser);
	assign cols = s_tdata[3:0];
	assign ridx = s_tdata[7:4];
	assign s_tready = !out_valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;

	assign hit_first = find_low(cols, 3'd0);
	assign hit_next = find_low(cols, {1'b0, held_q} + 3'd1);

	always_comb begin
		row_n = row_q;
		phase_n = phase_q;
		held_n = held_q;
		wait_n = wait_q;
		count_n = count_q;
		kvalid = 1'b0;
		kcode = '0;
		rdata = '0;
		rvalid = 1'b0;
		wr_en = 1'b0;
		if (enable_q) begin
			case (action)
				ACT_SCAN: begin
					case (phase_q)
						PH_DEBOUNCE: begin
							if (wait_q != 8'd0) begin
								wait_n = wait_q - 8'd1;
							end else if (!cols[held_q]) begin
								phase_n = PH_RELEASE;
							end else if (hit_next.found) begin
								held_n = hit_next.col;
								wait_n = debounce_q;
							end else begin
								row_n = row_q + 2'd1;
								phase_n = PH_SCAN;
							end
						end
						PH_RELEASE: begin
							if (cols[held_q]) begin
								kvalid = 1'b1;
								kcode = key_map(row_q, held_q);
								if (kcode != KEY_HASH && count_q < CNT_W'(BUFFER_DEPTH)) begin
									wr_en = 1'b1;
									count_n = count_q + CNT_W'(1);
								end
								row_n = '0;
								phase_n = PH_SCAN;
								held_n = '0;
								wait_n = '0;
							end
						end
						default: begin
							if (hit_first.found) begin
								held_n = hit_first.col;
								wait_n = debounce_q;
								phase_n = PH_DEBOUNCE;
							end else begin
								row_n = row_q + 2'd1;
							end
						end
					endcase
				end
				ACT_CLEAR: count_n = '0;
				ACT_READ: begin
					if (32'(ridx) < 32'(count_q)) begin
						rvalid = 1'b1;
						rdata = store_q[BUF_IDX_W'(ridx)];
					end
				end
				default: ;
			endcase
			drive = ~(4'b0001 << row_n);
		end else begin
			count_n = '0;
			row_n = '0;
			phase_n = PH_SCAN;
			held_n = '0;
			wait_n = '0;
			drive = 4'hF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			debounce_q <= DEBOUNCE_RESET;
			row_q <= '0;
			phase_q <= PH_SCAN;
			held_q <= '0;
			wait_q <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ENABLE: begin
					enable_q <= cfg_data[0];
					row_q <= '0;
					phase_q <= PH_SCAN;
					held_q <= '0;
					wait_q <= '0;
					count_q <= '0;
				end
				default: debounce_q <= cfg_data;
			endcase
		end else if (s_accept) begin
			row_q <= row_n;
			phase_q <= phase_n;
			held_q <= held_n;
			wait_q <= wait_n;
			count_q <= count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept && wr_en && !cfg_we) begin
			store_q[count_q[BUF_IDX_W-1:0]] <= kcode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			row_drive_q <= drive;
			key_valid_q <= kvalid;
			key_code_q <= kcode;
			count_out_q <= count_n;
			read_data_q <= rdata;
			read_valid_q <= rvalid;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = 32'({read_data_q, count_out_q, key_code_q, row_drive_q});
	assign m_tuser = {read_valid_q, key_valid_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= BUFFER_DEPTH)
		else $error("buffer fill above depth");

	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!enable_q |-> (count_q == '0 && phase_q == PH_SCAN && row_q == 2'd0))
		else $error("scan or buffer active while disabled");

	a_wait_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_DEBOUNCE |-> wait_q == 8'd0)
		else $error("debounce count left outside debounce");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(key_valid_q && read_valid_q))
		else $error("key and read reported together");

	a_key_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && key_valid_q) |-> key_code_q != 8'd0)
		else $error("reported key without code");

endmodule

// ===== tb/sv/kps_scan_checker.sv =====
`timescale 1ns / 100ps
// Checker for the keypad scanner: predicts each result from accepted items and
// register writes, then compares it with the m_* stream. Depends on kps_pkg.
module kps_scan_checker
	import kps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] col_levels, [7:4] read_index
	input  logic [1:0]  s_tuser,   // [1:0] action
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [3:0] row_drive, [11:4] key_code,
	                               // [16:12] buffer_count, [24:17] read_data
	input  logic [1:0]  m_tuser,   // [0] key_valid, [1] read_valid
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          errors,
	output int          pending,
	output int          keys_seen,
	output int          reads_hit
);

	localparam logic [127:0] KEY_CHARS = "123A456B789C*0#D";

	typedef struct packed {
		logic [3:0]       row_drive;
		logic             key_valid;
		logic [7:0]       key_code;
		logic [CNT_W-1:0] buffer_count;
		logic [7:0]       read_data;
		logic             read_valid;
	} scan_result_t;

	scan_result_t scan_results_q[$];
	scan_result_t want;
	scan_result_t got;

	logic             en_r;
	logic [7:0]       debounce_r;
	logic [1:0]       row_r;
	phase_t           phase_r;
	logic [1:0]       held_r;
	logic [7:0]       wait_r;
	logic [7:0]       key_buf [BUFFER_DEPTH];
	logic [CNT_W-1:0] fill_r;

	initial begin
		errors = 0;
		pending = 0;
		keys_seen = 0;
		reads_hit = 0;
	end

	// 4 means no pressed column at or above 'from'
	function automatic logic [2:0] first_pressed(input logic [3:0] cols, input logic [2:0] from);
		logic [2:0] hit;
		hit = 3'd4;
		for (int c = 3; c >= 0; c--) begin
			if (!cols[c] && 3'(c) >= from)
				hit = 3'(c);
		end
		return hit;
	endfunction

	task automatic scan_idle();
		row_r = 2'd0;
		phase_r = PH_SCAN;
		held_r = 2'd0;
		wait_r = 8'd0;
	endtask

	task automatic search_cols(input logic [3:0] cols, input logic [2:0] from);
		logic [2:0] c;
		c = first_pressed(cols, from);
		if (c != 3'd4) begin
			held_r = c[1:0];
			wait_r = debounce_r;
			phase_r = PH_DEBOUNCE;
		end else begin
			row_r = row_r + 2'd1;
			phase_r = PH_SCAN;
		end
	endtask

	task automatic predict_scan(input logic [1:0] act, input logic [3:0] cols,
			input logic [3:0] idx, output scan_result_t r);
		logic [3:0] pos;
		logic [7:0] code;
		r = '0;
		if (en_r) begin
			case (act)
				ACT_SCAN: begin
					if (phase_r == PH_DEBOUNCE) begin
						if (wait_r != 8'd0)
							wait_r = wait_r - 8'd1;
						else if (!cols[held_r])
							phase_r = PH_RELEASE;
						else
							search_cols(cols, {1'b0, held_r} + 3'd1);
					end else if (phase_r == PH_RELEASE) begin
						if (cols[held_r]) begin
							pos = ~{row_r, held_r};
							code = KEY_CHARS[{pos, 3'b000} +: 8];
							r.key_valid = 1'b1;
							r.key_code = code;
							if (code != KEY_HASH && fill_r < BUFFER_DEPTH) begin
								key_buf[fill_r[BUF_IDX_W-1:0]] = code;
								fill_r = fill_r + 1'b1;
							end
							scan_idle();
						end
					end else begin
						search_cols(cols, 3'd0);
					end
				end
				ACT_CLEAR: fill_r = '0;
				ACT_READ: begin
					if (idx < fill_r) begin
						r.read_valid = 1'b1;
						r.read_data = key_buf[idx];
					end
				end
				default: ;
			endcase
			r.row_drive = ~(4'b0001 << row_r);
		end else begin
			fill_r = '0;
			scan_idle();
			r.row_drive = 4'hF;
		end
		r.buffer_count = fill_r;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_r = 1'b0;
			debounce_r = DEBOUNCE_RESET;
			fill_r = '0;
			scan_idle();
			for (int i = 0; i < BUFFER_DEPTH; i++)
				key_buf[i] = 8'd0;
			scan_results_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE: begin
						en_r = cfg_data[0];
						scan_idle();
						fill_r = '0;
					end
					REG_DEBOUNCE: debounce_r = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.row_drive = m_tdata[3:0];
				got.key_code = m_tdata[11:4];
				got.buffer_count = m_tdata[16:12];
				got.read_data = m_tdata[24:17];
				got.key_valid = m_tuser[0];
				got.read_valid = m_tuser[1];
				if (scan_results_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result: row=%h key=%b/%h cnt=%0d read=%b/%h",
							got.row_drive, got.key_valid, got.key_code, got.buffer_count,
							got.read_valid, got.read_data);
					errors++;
				end else begin
					want = scan_results_q.pop_front();
					if (got !== want) begin
						if (errors < 10) begin
							$display("mismatch: exp row=%h key=%b/%h cnt=%0d read=%b/%h",
								want.row_drive, want.key_valid, want.key_code,
								want.buffer_count, want.read_valid, want.read_data);
							$display("          got row=%h key=%b/%h cnt=%0d read=%b/%h",
								got.row_drive, got.key_valid, got.key_code,
								got.buffer_count, got.read_valid, got.read_data);
						end
						errors++;
					end
					if (want.key_valid)
						keys_seen++;
					if (want.read_valid)
						reads_hit++;
				end
			end
			if (s_tvalid && s_tready) begin
				predict_scan(s_tuser, s_tdata[3:0], s_tdata[7:4], want);
				scan_results_q.push_back(want);
			end
			pending <= scan_results_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_matrix_keypad_scanner_top.sv =====
`timescale 1ns / 100ps
// Testbench top for matrix_keypad_scanner_top: drives key press sequences,
// buffer commands and register writes; kps_scan_checker does the checking.
module tb_matrix_keypad_scanner_top;
	import kps_pkg::*;

	localparam logic [1:0] ACT_NOP = 2'd3;
	localparam int LIMIT = 400000;
	localparam int SETTLE = 4;
	localparam int LONG_HOLD = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic [1:0]  s_tuser = 2'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic [0:0]  cfg_index = 1'b0;
	logic [7:0]  cfg_data = 8'd0;

	int errors, pending, keys_seen, reads_hit;
	int idle_pct = 0;
	int stall_pct = 0;
	int deb_now = 20;
	int items_sent = 0;
	int settings_run = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int cycle_cnt;

	always #1 clk = ~clk;

	matrix_keypad_scanner_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	kps_scan_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.errors   (errors),
		.pending  (pending),
		.keys_seen(keys_seen),
		.reads_hit(reads_hit)
	);

	// receiver: random stalls, plus a long hold on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	initial begin
		for (cycle_cnt = 0; cycle_cnt < LIMIT; cycle_cnt++)
			@(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", LIMIT, pending);
		$display("[matrix_keypad_scanner_top] ERROR");
		$finish;
	end

	task automatic send_item(input logic [1:0] act, input logic [3:0] cols, input logic [3:0] idx);
		while ($urandom_range(99, 0) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {idx, cols};
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [0:0] idx, input logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// column 'col' pressed (nothing lower) or released, other columns random
	function automatic logic [3:0] col_sample(input logic [1:0] col, input logic low);
		logic [3:0] v;
		v = 4'($urandom_range(15, 0));
		v[col] = !low;
		if (low)
			v = v | ((4'b0001 << col) - 4'b0001);
		return v;
	endfunction

	task automatic press_sequence();
		int gap;
		int hold;
		logic [1:0] col;
		gap = $urandom_range(2, 0);
		repeat (gap)
			send_item(ACT_SCAN, ($urandom_range(3, 0) == 0) ? 4'($urandom) : 4'hF, 4'($urandom));
		if ($urandom_range(9, 0) == 0)
			send_item($urandom_range(1, 0) ? ACT_NOP : ACT_SCAN, 4'($urandom), 4'($urandom));
		if ($urandom_range(4, 0) == 0)
			send_item(ACT_READ, 4'($urandom), 4'($urandom));
		if ($urandom_range(49, 0) == 0)
			send_item(ACT_CLEAR, 4'($urandom), 4'($urandom));
		col = 2'($urandom_range(3, 0));
		send_item(ACT_SCAN, col_sample(col, 1'b1), 4'($urandom));
		repeat (deb_now)
			send_item(ACT_SCAN, 4'($urandom), 4'($urandom));
		if ($urandom_range(7, 0) == 0) begin
			// bounce: column already released at recheck
			send_item(ACT_SCAN, col_sample(col, 1'b0), 4'($urandom));
		end else begin
			hold = $urandom_range(2, 0);
			repeat (hold + 1)
				send_item(ACT_SCAN, col_sample(col, 1'b1), 4'($urandom));
			if ($urandom_range(5, 0) == 0)
				send_item(ACT_READ, 4'($urandom), 4'($urandom));
			send_item(ACT_SCAN, col_sample(col, 1'b0), 4'($urandom));
		end
	endtask

	task automatic run_phase(input logic [7:0] deb, input logic re_enable, input int spct,
			input int rpct, input int n_items, input logic pressure);
		int start;
		deb_now = deb;
		cfg_write(REG_DEBOUNCE, deb);
		if (re_enable)
			cfg_write(REG_ENABLE, 8'd1);
		settings_run++;
		idle_pct = spct;
		stall_pct <= rpct;
		if (pressure)
			hold_req <= hold_req + 1;
		start = items_sent;
		while (items_sent - start < n_items) begin
			press_sequence();
			if (pressure && items_sent - start >= n_items / 2) begin
				drain();
				pressure = 1'b0;
			end
		end
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// out of reset: disabled, status only
		send_item(ACT_SCAN, 4'h0, 4'h0);
		send_item(ACT_READ, 4'h0, 4'h0);
		send_item(ACT_CLEAR, 4'hF, 4'hF);
		drain();

		deb_now = 0;
		cfg_write(REG_DEBOUNCE, 8'd0);
		cfg_write(REG_ENABLE, 8'd1);
		settings_run++;
		send_item(ACT_READ, 4'hF, 4'h0);   // empty buffer
		send_item(ACT_READ, 4'hF, 4'hF);
		send_item(ACT_SCAN, 4'hF, 4'h0);   // no press, row advances
		send_item(ACT_SCAN, 4'h0, 4'h0);   // detect lowest column
		send_item(ACT_SCAN, 4'h0, 4'h0);   // recheck passes
		send_item(ACT_SCAN, 4'h0, 4'h0);   // still held
		send_item(ACT_SCAN, 4'hF, 4'h0);   // released, key out
		send_item(ACT_READ, 4'hF, 4'h0);
		send_item(ACT_READ, 4'hF, 4'h1);
		send_item(ACT_SCAN, 4'hE, 4'h0);   // detect column 0
		send_item(ACT_SCAN, 4'h3, 4'h0);   // recheck fails, column 2 taken
		send_item(ACT_SCAN, 4'h3, 4'h0);
		send_item(ACT_SCAN, 4'hF, 4'h0);
		send_item(ACT_SCAN, 4'h7, 4'h0);   // detect column 3
		send_item(ACT_SCAN, 4'hF, 4'h0);   // recheck fails, nothing above
		send_item(ACT_SCAN, 4'hF, 4'h0);
		send_item(ACT_SCAN, 4'hF, 4'h0);
		send_item(ACT_SCAN, 4'hB, 4'h0);   // '#' on row 3: reported, not stored
		send_item(ACT_SCAN, 4'hB, 4'h0);
		send_item(ACT_SCAN, 4'hF, 4'h0);
		send_item(ACT_NOP, 4'h0, 4'hF);
		send_item(ACT_CLEAR, 4'h0, 4'h0);
		send_item(ACT_READ, 4'h0, 4'h0);
		send_item(ACT_SCAN, 4'h0, 4'h0);
		drain();

		run_phase(8'd0, 1'b1, 0, 0, 80, 1'b0);
		run_phase(8'd1, 1'b0, 81, 0, 80, 1'b0);
		run_phase(8'd3, 1'b1, 0, 81, 80, 1'b1);
		run_phase(8'd2, 1'b0, 21, 21, 80, 1'b0);

		cfg_write(REG_ENABLE, 8'd0);
		settings_run++;
		repeat (12)
			send_item(2'($urandom_range(3, 0)), 4'($urandom), 4'($urandom));
		drain();

		run_phase(8'd255, 1'b1, 0, 0, 1, 1'b0);
		run_phase(8'd20, 1'b0, 21, 21, 60, 1'b0);

		$display("%0d items under %0d register settings; %0d keys reported, %0d buffer reads hit",
			items_sent, settings_run, keys_seen, reads_hit);
		if (errors == 0) begin
			$display("[matrix_keypad_scanner_top] OK");
		end else begin
			$display("%0d failures", errors);
			$display("[matrix_keypad_scanner_top] ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/kps_pkg.sv
src/matrix_keypad_scanner_top.sv
tb/sv/kps_scan_checker.sv
tb/sv/tb_matrix_keypad_scanner_top.sv
